@@ rtl/ata_tf_pkg.sv @@
// Shared types and constants for the ATA task-file command builder.
`default_nettype none

package ata_tf_pkg;

   localparam int DVD_W = 48;
   localparam int DVS_W = 13;
   localparam int STEP_W = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [STEP_W-1:0] DIV_STEPS_TRACK = STEP_W'(DVD_W);
   localparam logic [STEP_W-1:0] DIV_STEPS_HEAD = STEP_W'(DVS_W);

   localparam logic [47:0] LBA28_LIMIT = 48'h000_0FFF_FFFF;
   localparam logic [7:0] DEVSEL_LBA = 8'hE0;
   localparam logic [7:0] DEVSEL_CHS = 8'hA0;
   localparam logic [7:0] CMD_READ = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;
   localparam logic [7:0] CMD_READ_EXT = 8'h24;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   localparam logic [1:0] CSR_LBA_SUPPORTED = 2'd0;
   localparam logic [1:0] CSR_SECTORS_PER_TRACK = 2'd1;
   localparam logic [1:0] CSR_HEAD_COUNT = 2'd2;
   localparam logic [1:0] CSR_SLAVE_SELECT = 2'd3;

   localparam logic OP_READ = 1'b0;

   typedef enum logic [3:0] {
      REG_DEVSEL   = 4'd0,
      REG_COUNT_HI = 4'd1,
      REG_LBA3     = 4'd2,
      REG_LBA4     = 4'd3,
      REG_LBA5     = 4'd4,
      REG_COUNT_LO = 4'd5,
      REG_LBA0     = 4'd6,
      REG_LBA1     = 4'd7,
      REG_LBA2     = 4'd8,
      REG_COMMAND  = 4'd9
   } reg_code_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_TRACK,
      FR_HEAD,
      FR_PUSH
   } front_state_type;

   typedef struct packed {
      logic       lba_supported;
      logic [7:0] sectors_per_track;
      logic [4:0] head_count;
      logic       slave_select;
   } cfg_type;

   typedef struct packed {
      logic       ext;
      logic [7:0] devsel;
      logic [7:0] count_hi;
      logic [7:0] lba3;
      logic [7:0] lba4;
      logic [7:0] lba5;
      logic [7:0] count_lo;
      logic [7:0] lba0;
      logic [7:0] lba1;
      logic [7:0] lba2;
      logic [7:0] command;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/ata_tf_div.sv @@
// Bit-serial restoring divider shared by the cylinder and head passes.
`default_nettype none

module ata_tf_div
   import ata_tf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits = trial >= {1'b0, dvs_ff};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = div_req.steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = dvd_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/ata_tf_front.sv @@
// Request intake: classifies the addressing form and builds the register bytes.
`default_nettype none

module ata_tf_front
   import ata_tf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        q_full,
   output logic             q_push,
   output cmd_type          q_entry,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             front_idle
);

   front_state_type state_ff, state_in;
   logic        op_ff, op_in;
   logic [7:0]  cnt_lo_ff, cnt_lo_in;
   logic [15:0] cyl_ff, cyl_in;

   logic [47:0]      req_lba;
   logic [15:0]      req_count;
   logic [7:0]       spt_eff;
   logic [4:0]       heads_eff;
   logic [DVS_W-1:0] geometry;
   logic [7:0]       sel;
   logic             ext;
   cmd_type          lba_entry;
   cmd_type          chs_entry;

   assign req_lba = req_tdata[47:0];
   assign req_count = req_tdata[63:48];
   assign spt_eff = (cfg.sectors_per_track == 8'd0) ? 8'd1 : cfg.sectors_per_track;
   assign heads_eff = (cfg.head_count == 5'd0) ? 5'd1 : cfg.head_count;
   assign geometry = DVS_W'(DVS_W'(spt_eff) * DVS_W'(heads_eff));
   assign sel = {3'b000, cfg.slave_select, 4'b0000};
   assign ext = req_lba > LBA28_LIMIT;

   always_comb begin
      lba_entry.ext = ext;
      lba_entry.devsel = ext ? (DEVSEL_LBA | sel) : (DEVSEL_LBA | sel | {4'b0000, req_lba[27:24]});
      lba_entry.count_hi = req_count[15:8];
      lba_entry.lba3 = req_lba[31:24];
      lba_entry.lba4 = req_lba[39:32];
      lba_entry.lba5 = req_lba[47:40];
      lba_entry.count_lo = req_count[7:0];
      lba_entry.lba0 = req_lba[7:0];
      lba_entry.lba1 = req_lba[15:8];
      lba_entry.lba2 = req_lba[23:16];
      if (ext) begin
         lba_entry.command = (req_tuser == OP_READ) ? CMD_READ_EXT : CMD_WRITE_EXT;
      end else begin
         lba_entry.command = (req_tuser == OP_READ) ? CMD_READ : CMD_WRITE;
      end

      chs_entry.ext = 1'b0;
      chs_entry.devsel = DEVSEL_CHS | sel | {4'b0000, div_rsp.quotient[3:0]};
      chs_entry.count_hi = '0;
      chs_entry.lba3 = '0;
      chs_entry.lba4 = '0;
      chs_entry.lba5 = '0;
      chs_entry.count_lo = cnt_lo_ff;
      chs_entry.lba0 = div_rsp.remainder[7:0] + 8'd1;
      chs_entry.lba1 = cyl_ff[7:0];
      chs_entry.lba2 = cyl_ff[15:8];
      chs_entry.command = (op_ff == OP_READ) ? CMD_READ : CMD_WRITE;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cnt_lo_in = cnt_lo_ff;
      cyl_in = cyl_ff;
      q_push = 1'b0;
      q_entry = lba_entry;
      req_tready = 1'b0;
      div_req.start = 1'b0;
      div_req.steps = DIV_STEPS_TRACK;
      div_req.dividend = req_lba;
      div_req.divisor = geometry;
      unique case (state_ff)
         FR_IDLE: begin
            req_tready = !q_full;
            if (req_tvalid && !q_full) begin
               op_in = req_tuser;
               cnt_lo_in = req_count[7:0];
               if (cfg.lba_supported) begin
                  q_push = 1'b1;
               end else begin
                  div_req.start = 1'b1;
                  state_in = FR_TRACK;
               end
            end
         end
         FR_TRACK: begin
            if (div_rsp.done) begin
               cyl_in = div_rsp.quotient[15:0];
               div_req.start = 1'b1;
               div_req.steps = DIV_STEPS_HEAD;
               div_req.dividend = {div_rsp.remainder, {(DVD_W-DVS_W){1'b0}}};
               div_req.divisor = DVS_W'(spt_eff);
               state_in = FR_HEAD;
            end
         end
         FR_HEAD: begin
            if (div_rsp.done) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            q_entry = chs_entry;
            if (!q_full) begin
               q_push = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      cnt_lo_ff <= cnt_lo_in;
      cyl_ff <= cyl_in;
   end

   assign front_idle = state_ff == FR_IDLE;

endmodule

`default_nettype wire

@@ rtl/ata_tf_queue.sv @@
// Short command queue between the intake and the register-write sequencer.
`default_nettype none

module ata_tf_queue
   import ata_tf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_entry,
   input  wire logic    pop,
   output cmd_type      head_entry,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = mem_ff[rd_ptr_ff];
   assign full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

endmodule

`default_nettype wire

@@ rtl/ata_tf_back.sv @@
// Register-write sequencer: walks a queued command out one task-file write per cycle while rsp_tready is high.
`default_nettype none

module ata_tf_back
   import ata_tf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire cmd_type     q_entry,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   reg_code_type step_ff, step_in;
   logic         valid_ff, valid_in;
   logic [3:0]   code_ff;
   logic [7:0]   value_ff;
   logic         last_ff;
   logic         load;
   logic [7:0]   value_sel;

   assign load = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      value_sel = q_entry.command;
      step_in = step_ff;
      unique case (step_ff)
         REG_DEVSEL: begin
            value_sel = q_entry.devsel;
            step_in = q_entry.ext ? REG_COUNT_HI : REG_COUNT_LO;
         end
         REG_COUNT_HI: begin
            value_sel = q_entry.count_hi;
            step_in = REG_LBA3;
         end
         REG_LBA3: begin
            value_sel = q_entry.lba3;
            step_in = REG_LBA4;
         end
         REG_LBA4: begin
            value_sel = q_entry.lba4;
            step_in = REG_LBA5;
         end
         REG_LBA5: begin
            value_sel = q_entry.lba5;
            step_in = REG_COUNT_LO;
         end
         REG_COUNT_LO: begin
            value_sel = q_entry.count_lo;
            step_in = REG_LBA0;
         end
         REG_LBA0: begin
            value_sel = q_entry.lba0;
            step_in = REG_LBA1;
         end
         REG_LBA1: begin
            value_sel = q_entry.lba1;
            step_in = REG_LBA2;
         end
         REG_LBA2: begin
            value_sel = q_entry.lba2;
            step_in = REG_COMMAND;
         end
         REG_COMMAND: begin
            value_sel = q_entry.command;
            step_in = REG_DEVSEL;
         end
         default: step_in = REG_DEVSEL;
      endcase
      if (!load) begin
         step_in = step_ff;
      end
      valid_in = load || (valid_ff && !rsp_tready);
   end

   assign q_pop = load && (step_ff == REG_COMMAND);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= REG_DEVSEL;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         code_ff <= step_ff;
         value_ff <= value_sel;
         last_ff <= step_ff == REG_COMMAND;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {4'b0000, value_ff, code_ff};
   assign rsp_tlast = last_ff;

endmodule

`default_nettype wire

@@ rtl/ata_taskfile_command_builder.sv @@
// Top level of the ATA task-file command builder.
// Turns one PIO read or write request into its task-file register writes, one write per
// rsp transaction, ending with the command write marked by rsp_tlast. With LBA enabled a
// request is classified and queued in the cycle it is taken; the sequencer then sends 6
// writes (28-bit form) or 10 writes (48-bit form), one per cycle while rsp_tready is high,
// and requests arrive back to back into a two-entry queue. In CHS form the address goes
// through a shared one-bit-per-cycle divider, 48 steps by sectors_per_track * head_count
// and then 13 steps by sectors_per_track, so such a request holds the intake until both
// passes end and the queue has room to take it. Configuration writes take effect at once
// and must come only while no request is in flight.
`default_nettype none

module ata_taskfile_command_builder
   import ata_tf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [47:0] lba, [63:48] sector_count
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [3:0] register_code, [11:4] write_value, [15:12] zero
   output logic             rsp_tlast
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_full;
   logic        q_empty;
   logic        q_push;
   logic        q_pop;
   cmd_type     push_entry;
   cmd_type     head_entry;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        front_idle;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LBA_SUPPORTED: cfg_in.lba_supported = csr_wdata[0];
            CSR_SECTORS_PER_TRACK: cfg_in.sectors_per_track = csr_wdata;
            CSR_HEAD_COUNT: cfg_in.head_count = csr_wdata[4:0];
            CSR_SLAVE_SELECT: cfg_in.slave_select = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lba_supported <= 1'b1;
         cfg_ff.sectors_per_track <= 8'd63;
         cfg_ff.head_count <= 5'd16;
         cfg_ff.slave_select <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ata_tf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ata_tf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .front_idle (front_idle)
   );

   ata_tf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   ata_tf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");

   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> !front_idle)
      else $error("divider finished with intake idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[3:0] == 4'(REG_DEVSEL)))
      else $error("sequence did not restart at device select");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'(REG_COMMAND))))
      else $error("last flag not on command write");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the ATA task-file command builder: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;
   import ata_tf_pkg::*;

   localparam logic OP_WRITE = ~OP_READ;
   localparam int NUM_DIRECTED = 19;
   localparam int RANDOM_PER_SETTING = 40;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      reg_code_type code;
      logic [7:0]   value;
      logic         last;
   } tf_write_type;

   typedef struct packed {
      logic       wr_cfg;
      cfg_type    cfg;
      logic       op;
      logic [47:0] lba;
      logic [15:0] count;
      logic       typed;
      logic [7:0] exp_devsel;
      logic [7:0] exp_command;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_LBA_SUPPORTED;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = 64'h0;
   logic        req_tuser = OP_READ;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   tf_write_type tf_writes_due [$];
   cfg_type      shadow_cfg = '{1'b1, 8'd63, 5'd16, 1'b0};
   int           mismatches = 0;
   int           tx_idle_pct = 10;
   int           rx_idle_pct = 30;
   bit           rx_hold_req = 1'b0;
   int           rx_hold_left = 0;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b0}, OP_READ, 48'h0000_0000_0000, 16'h0000,
        1'b1, DEVSEL_LBA, CMD_READ},
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b0}, OP_WRITE, 48'h0000_0FFF_FFFF, 16'hFFFF,
        1'b1, DEVSEL_LBA | 8'h0F, CMD_WRITE},
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b0}, OP_READ, 48'h0000_1000_0000, 16'h1234,
        1'b1, DEVSEL_LBA, CMD_READ_EXT},
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b0}, OP_WRITE, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
        1'b1, DEVSEL_LBA, CMD_WRITE_EXT},
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b0}, OP_READ, 48'h8000_0000_0000, 16'h0100,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b1, 8'd63, 5'd16, 1'b1}, OP_READ, 48'h0000_00AB_CDEF, 16'h00FF,
        1'b1, DEVSEL_LBA | 8'h10, CMD_READ},
      '{1'b0, '{1'b1, 8'd63, 5'd16, 1'b1}, OP_WRITE, 48'h0001_0000_0000, 16'h8000,
        1'b1, DEVSEL_LBA | 8'h10, CMD_WRITE_EXT},
      '{1'b1, '{1'b0, 8'd63, 5'd16, 1'b0}, OP_READ, 48'h0000_0000_0000, 16'h0001,
        1'b1, DEVSEL_CHS, CMD_READ},
      '{1'b0, '{1'b0, 8'd63, 5'd16, 1'b0}, OP_WRITE, 48'h0000_0000_003E, 16'h00FF,
        1'b1, DEVSEL_CHS, CMD_WRITE},
      '{1'b0, '{1'b0, 8'd63, 5'd16, 1'b0}, OP_READ, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
        1'b0, 8'h00, 8'h00},
      '{1'b0, '{1'b0, 8'd63, 5'd16, 1'b0}, OP_WRITE, 48'h0123_4567_89AB, 16'h5A5A,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b0, 8'd0, 5'd0, 1'b1}, OP_READ, 48'h0000_0000_0005, 16'h0003,
        1'b1, DEVSEL_CHS | 8'h10, CMD_READ},
      '{1'b0, '{1'b0, 8'd0, 5'd0, 1'b1}, OP_WRITE, 48'hFFFF_FFFF_FFFF, 16'h0000,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b0, 8'd255, 5'd31, 1'b0}, OP_READ, 48'h0000_0000_13EC, 16'h0010,
        1'b0, 8'h00, 8'h00},
      '{1'b0, '{1'b0, 8'd255, 5'd31, 1'b0}, OP_WRITE, 48'h0000_0000_00FE, 16'h0020,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b0, 8'd1, 5'd1, 1'b1}, OP_READ, 48'h0000_0001_0000, 16'h0040,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b0, 8'd255, 5'd17, 1'b0}, OP_WRITE, 48'h7FFF_FFFF_FFFF, 16'h0080,
        1'b0, 8'h00, 8'h00},
      '{1'b1, '{1'b1, 8'd1, 5'd1, 1'b0}, OP_READ, 48'h0000_0F00_0000, 16'h00FF,
        1'b1, DEVSEL_LBA | 8'h0F, CMD_READ},
      '{1'b0, '{1'b1, 8'd1, 5'd1, 1'b0}, OP_WRITE, 48'h0000_0000_0001, 16'h0001,
        1'b0, 8'h00, 8'h00}
   };

   ata_taskfile_command_builder i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                  input logic [7:0] got_v);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
   endtask

   task automatic queue_taskfile_writes(input logic op, input logic [47:0] lba,
                                        input logic [15:0] cnt, input logic typed,
                                        input logic [7:0] typed_devsel,
                                        input logic [7:0] typed_command);
      tf_write_type seq [10];
      int n;
      logic [7:0] sel;
      logic [47:0] spt, heads, track, sector, head, cyl;
      sel = {3'b000, shadow_cfg.slave_select, 4'h0};
      spt = (shadow_cfg.sectors_per_track == 8'd0) ? 48'd1 : 48'(shadow_cfg.sectors_per_track);
      heads = (shadow_cfg.head_count == 5'd0) ? 48'd1 : 48'(shadow_cfg.head_count);
      if (shadow_cfg.lba_supported) begin
         if (lba > LBA28_LIMIT) begin
            seq[0] = '{REG_DEVSEL, DEVSEL_LBA | sel, 1'b0};
            seq[1] = '{REG_COUNT_HI, cnt[15:8], 1'b0};
            seq[2] = '{REG_LBA3, lba[31:24], 1'b0};
            seq[3] = '{REG_LBA4, lba[39:32], 1'b0};
            seq[4] = '{REG_LBA5, lba[47:40], 1'b0};
            seq[5] = '{REG_COUNT_LO, cnt[7:0], 1'b0};
            seq[6] = '{REG_LBA0, lba[7:0], 1'b0};
            seq[7] = '{REG_LBA1, lba[15:8], 1'b0};
            seq[8] = '{REG_LBA2, lba[23:16], 1'b0};
            seq[9] = '{REG_COMMAND, (op == OP_READ) ? CMD_READ_EXT : CMD_WRITE_EXT, 1'b1};
            n = 10;
         end else begin
            seq[0] = '{REG_DEVSEL, DEVSEL_LBA | sel | {4'h0, lba[27:24]}, 1'b0};
            seq[1] = '{REG_COUNT_LO, cnt[7:0], 1'b0};
            seq[2] = '{REG_LBA0, lba[7:0], 1'b0};
            seq[3] = '{REG_LBA1, lba[15:8], 1'b0};
            seq[4] = '{REG_LBA2, lba[23:16], 1'b0};
            seq[5] = '{REG_COMMAND, (op == OP_READ) ? CMD_READ : CMD_WRITE, 1'b1};
            n = 6;
         end
      end else begin
         track = lba / spt;
         sector = (lba % spt) + 48'd1;
         head = track % heads;
         cyl = track / heads;
         seq[0] = '{REG_DEVSEL, DEVSEL_CHS | sel | {4'h0, head[3:0]}, 1'b0};
         seq[1] = '{REG_COUNT_LO, cnt[7:0], 1'b0};
         seq[2] = '{REG_LBA0, sector[7:0], 1'b0};
         seq[3] = '{REG_LBA1, cyl[7:0], 1'b0};
         seq[4] = '{REG_LBA2, cyl[15:8], 1'b0};
         seq[5] = '{REG_COMMAND, (op == OP_READ) ? CMD_READ : CMD_WRITE, 1'b1};
         n = 6;
      end
      if (typed) begin
         seq[0].value = typed_devsel;
         seq[n-1].value = typed_command;
      end
      for (int i = 0; i < n; i++)
         tf_writes_due.push_back(seq[i]);
   endtask

   // Call at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(input logic op, input logic [47:0] lba, input logic [15:0] cnt,
                               input logic typed, input logic [7:0] typed_devsel,
                               input logic [7:0] typed_command);
      req_tvalid <= 1'b1;
      req_tdata <= {cnt, lba};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      queue_taskfile_writes(op, lba, cnt, typed, typed_devsel, typed_command);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (tf_writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      csr_we <= 1'b1;
      csr_index <= CSR_LBA_SUPPORTED;
      csr_wdata <= {7'h00, c.lba_supported};
      @(negedge clock);
      csr_index <= CSR_SECTORS_PER_TRACK;
      csr_wdata <= c.sectors_per_track;
      @(negedge clock);
      csr_index <= CSR_HEAD_COUNT;
      csr_wdata <= {3'b000, c.head_count};
      @(negedge clock);
      csr_index <= CSR_SLAVE_SELECT;
      csr_wdata <= {7'h00, c.slave_select};
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_cfg = c;
   endtask

   function automatic cfg_type pick_settings(input int slot);
      cfg_type c;
      c.lba_supported = (slot % 2 == 0);
      case ($urandom_range(4))
         0: c.sectors_per_track = 8'd0;
         1: c.sectors_per_track = 8'd1;
         2: c.sectors_per_track = 8'd255;
         default: c.sectors_per_track = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(5))
         0: c.head_count = 5'd0;
         1: c.head_count = 5'd1;
         2: c.head_count = 5'd16;
         3: c.head_count = 5'd31;
         default: c.head_count = 5'($urandom_range(1, 31));
      endcase
      c.slave_select = 1'($urandom_range(1));
      return c;
   endfunction

   function automatic logic [47:0] pick_lba();
      logic [47:0] v;
      case ($urandom_range(5))
         0: v = 48'($urandom_range(0, 255));
         1: v = {20'h0, 28'($urandom)};
         2: v = 48'h0000_0FFF_FFFE + 48'($urandom_range(0, 3));
         3: v = {16'($urandom), 32'($urandom)};
         4: v = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
         default: v = {16'h0, 32'($urandom)};
      endcase
      return v;
   endfunction

   always @(negedge clock) begin
      if (rx_hold_req) begin
         rx_hold_left = HOLD_OFF_CYCLES;
         rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      tf_write_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tf_writes_due.size() == 0) begin
            report_mismatch("register write with nothing due", 8'h00, rsp_tdata[11:4]);
         end else begin
            due = tf_writes_due.pop_front();
            if (rsp_tdata[3:0] != due.code)
               report_mismatch("register_code", 8'(due.code), 8'(rsp_tdata[3:0]));
            if (rsp_tdata[11:4] != due.value)
               report_mismatch("write_value", due.value, rsp_tdata[11:4]);
            if (rsp_tlast != due.last)
               report_mismatch("last", 8'(due.last), 8'(rsp_tlast));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL ata_taskfile_command_builder");
      $finish;
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].wr_cfg) begin
            drain_and_settle();
            write_settings(directed_rows[i].cfg);
         end
         send_request(directed_rows[i].op, directed_rows[i].lba, directed_rows[i].count,
                      directed_rows[i].typed, directed_rows[i].exp_devsel,
                      directed_rows[i].exp_command);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 14;
               rx_idle_pct = 71;
            end
            1: begin
               tx_idle_pct = 71;
               rx_idle_pct = 14;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int slot = 0; slot < 4; slot++) begin
            drain_and_settle();
            write_settings(pick_settings(slot));
            if (phase == 0 && slot == 0)
               rx_hold_req = 1'b1;
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
               while ($urandom_range(99) < tx_idle_pct) begin
                  req_tvalid <= 1'b0;
                  @(negedge clock);
               end
               send_request(1'($urandom_range(1)), pick_lba(), 16'($urandom), 1'b0,
                            8'h00, 8'h00);
            end
         end
      end

      drain_and_settle();
      if (mismatches == 0 && tf_writes_due.size() == 0)
         $display("PASS ata_taskfile_command_builder");
      else
         $display("FAIL ata_taskfile_command_builder");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ata_tf_pkg.sv
rtl/ata_tf_div.sv
rtl/ata_tf_front.sv
rtl/ata_tf_queue.sv
rtl/ata_tf_back.sv
rtl/ata_taskfile_command_builder.sv
tb/testbench.sv
